@@ sv/pial_pkg.sv @@
// ----------------------------------------------------------------------------
// pial_pkg
// Shared types and constants for the position-indexed array list.
// ----------------------------------------------------------------------------
package pial_pkg;

    localparam int CAPACITY   = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int POS_W      = 5;
    localparam int OP_W       = 2;
    localparam int LIM_W      = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the captured operation
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic item_held;  // an item is captured and not yet applied
    } t_dp_stat;

endpackage

@@ sv/pial_ctrl.sv @@
// ----------------------------------------------------------------------------
// pial_ctrl
// Handshake sequencer: capture, apply, present result.
// ----------------------------------------------------------------------------
module pial_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  pial_pkg::t_dp_stat i_stat,
    output pial_pkg::t_ctl_cmd o_cmd
);
    import pial_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.item_held) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_cmd.load = o_s_tready && i_s_tvalid;
    assign o_cmd.exec = (r_state == ST_EXEC) && i_stat.item_held;

endmodule

@@ sv/pial_dp.sv @@
// ----------------------------------------------------------------------------
// pial_dp
// List cells, entry count, limit register and result registers.
// ----------------------------------------------------------------------------
module pial_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pial_pkg::t_ctl_cmd              i_cmd,
    output pial_pkg::t_dp_stat              o_stat,
    input  logic                            i_cfg_wr,
    input  logic [pial_pkg::LIM_W-1:0]      i_cfg_data,
    input  logic [pial_pkg::OP_W-1:0]       i_operation,
    input  logic signed [pial_pkg::POS_W-1:0] i_position,
    input  logic [pial_pkg::DATA_W-1:0]     i_new_value,
    output logic                            o_status,
    output logic [pial_pkg::DATA_W-1:0]     o_read_value,
    output logic [pial_pkg::CNT_W-1:0]      o_item_count
);
    import pial_pkg::*;

    // 6-bit signed compares cover position -16..15 against count 0..16
    localparam int CMP_W = (POS_W > CNT_W ? POS_W : CNT_W) + 1;

    logic [DATA_W-1:0]        r_cells [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [LIM_W-1:0]         r_limit;
    logic                     r_held;
    logic [OP_W-1:0]          r_op;
    logic signed [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0]        r_val;
    logic                     r_status;
    logic [DATA_W-1:0]        r_rd;

    logic signed [CMP_W-1:0]  pos_s;
    logic signed [CMP_W-1:0]  cnt_s;
    logic signed [CMP_W-1:0]  ins_at;
    logic [CNT_W-1:0]         eff_lim;
    logic                     in_range;
    logic                     ins_ok;
    logic                     del_ok;
    logic                     rd_ok;

    always_comb begin
        pos_s   = CMP_W'(r_pos);
        cnt_s   = $signed({1'b0, r_count});
        ins_at  = pos_s + CMP_W'(1);
        eff_lim = (r_limit > LIM_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(r_limit);
        in_range = (pos_s >= 0) && (pos_s < cnt_s);
        rd_ok  = (r_op == OP_READ) && in_range;
        del_ok = (r_op == OP_DELETE) && in_range;
        ins_ok = (r_op == OP_INSERT) && (pos_s >= -CMP_W'(1)) && (pos_s < cnt_s)
                 && (r_count < eff_lim);
    end

    // one cell per entry, each takes data only from its neighbours or the new value
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                if (ins_ok) begin
                    if (ins_at == CMP_W'(i)) begin
                        r_cells[i] <= r_val;
                    end else if (ins_at < CMP_W'(i)) begin
                        r_cells[i] <= r_cells[(i == 0) ? 0 : i - 1];
                    end
                end else if (del_ok) begin
                    if ((pos_s <= CMP_W'(i)) && (i < CAPACITY - 1)) begin
                        r_cells[i] <= r_cells[(i == CAPACITY - 1) ? i : i + 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= LIMIT_RESET;
            r_held  <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_held <= 1'b1;
            end else if (i_cmd.exec) begin
                r_held <= 1'b0;
            end
            if (i_cmd.exec) begin
                if (ins_ok) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (del_ok) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_val <= i_new_value;
        end
        if (i_cmd.exec) begin
            r_status <= !(rd_ok || ins_ok || del_ok);
            r_rd     <= rd_ok ? r_cells[r_pos[IDX_W-1:0]] : '0;
        end
    end

    assign o_stat.item_held = r_held;
    assign o_status     = r_status;
    assign o_read_value = r_rd;
    assign o_item_count = r_count;

endmodule

@@ sv/position_indexed_array_list_unit.sv @@
// ----------------------------------------------------------------------------
// position_indexed_array_list_unit
// Ordered list of signed 32-bit values with read, insert-after and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis): one transfer per operation; tdata carries
//   operation, position and new_value. Master stream (m_axis): exactly one
//   transfer per operation with status, read_value and item_count.
//   Config channel (cfg): writes capacity_limit; always ready. The user
//   must write it only while the unit is idle; the unit does not enforce it.
// Timing:
//   An operation is taken in the idle state, applied to the list cells in
//   the exec state, and its result is offered from the out state on. One
//   operation is in flight at a time: the unit holds a single captured
//   item and takes no new one until the receiver has accepted the result.
//   Insert and delete update the cells from the affected position on at once.
// Reset:
//   Synchronous, active low. The list is emptied (count zero) and the limit
//   returns to 16. Cell contents are not cleared; only counted cells are read.
// Stalls:
//   While the master side stalls the result holds and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module position_indexed_array_list_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] operation, [6:2] position, [38:7] new_value, [39] zero
    input  logic [pial_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] status, [32:1] read_value, [37:33] item_count, [39:38] zero
    output logic [pial_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pial_pkg::LIM_W-1:0]          i_cfg_data
);
    import pial_pkg::*;

    t_ctl_cmd           cmd;
    t_dp_stat           stat;
    logic               status;
    logic [DATA_W-1:0]  read_value;
    logic [CNT_W-1:0]   item_count;

    // limit register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    pial_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pial_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_wr     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (s_axis_tdata[1:0]),
        .i_position   (s_axis_tdata[6:2]),
        .i_new_value  (s_axis_tdata[38:7]),
        .o_status     (status),
        .o_read_value (read_value),
        .o_item_count (item_count)
    );

    assign m_axis_tdata = {2'b00, item_count, read_value, status};

    // ---- checks ----
    // never taking an item while a result is still offered
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while result pending");

    // reported count never exceeds the cell count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[37:33] <= CNT_W'(CAPACITY)))
        else $error("item count above capacity");

    // a failed operation reports a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
        else $error("error result with non-zero read value");

    // an accepted item is applied in the exec state, then its result is offered
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("result not offered on time");

endmodule

@@ tb/sv/tb_position_indexed_array_list_unit.sv @@
// ----------------------------------------------------------------------------
// tb_position_indexed_array_list_unit
// Self-checking bench for the position-indexed array list unit.
// A short directed run covers empty, front, middle and end cases and bad
// positions. It is followed by constrained-by-hand random phases at several
// capacity limits (including 0, 1, a limit below the count and one above
// CAPACITY) under varying source idle and sink stall rates. Each result is
// checked field by field against an in-bench model of the list.
// ----------------------------------------------------------------------------
module tb_position_indexed_array_list_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import pial_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200_000;

    // op code 3 has no package name; the unit must reject it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one list operation as carried on the slave stream
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;     // two's complement
        logic [DATA_W-1:0] value;
    } list_op_t;

    // one result as carried on the master stream
    typedef struct packed {
        logic              status;  // 1 = refused
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  item_count;
    } list_result_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    // [1:0] operation, [6:2] position, [38:7] new_value, [39] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    // [0] status, [32:1] read_value, [37:33] item_count, [39:38] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [LIM_W-1:0]       i_cfg_data     = '0;

    position_indexed_array_list_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    list_op_t     op_backlog[$];       // ops waiting for the driver
    list_result_t pending_results[$];  // predicted results, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int ops_issued     = 0;   // pushed into the backlog
    int ops_taken      = 0;   // transfers accepted on the slave side
    int results_seen   = 0;   // transfers accepted on the master side
    int refusals       = 0;   // results predicted with status 1
    int limits_applied = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // model of the list, advanced at each accepted transfer
    logic [DATA_W-1:0] list_cells [CAPACITY];
    int                list_len;
    logic [LIM_W-1:0]  limit_reg;

    // generator-side view of the count, used only to aim positions
    int gen_len;
    int gen_lim;

    // ------------------------------------------------------------------------
    // List model: applies one op and returns the result it must produce.
    // Any refused op leaves the list untouched.
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_list_op(input list_op_t item);
        list_result_t res;
        int           p;
        int           lim;
        res        = '0;
        res.status = 1'b1;
        p          = $signed(item.pos);
        lim        = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
        case (item.op)
            OP_READ: begin
                if (p >= 0 && p < list_len) begin
                    res.read_value = list_cells[p];
                    res.status     = 1'b0;
                end
            end
            OP_INSERT: begin
                // insert after p; -1 puts the value at the front
                if (p >= -1 && p <= list_len - 1 && list_len < lim) begin
                    for (int j = list_len - 1; j > p; j--)
                        list_cells[j + 1] = list_cells[j];
                    list_cells[p + 1] = item.value;
                    list_len++;
                    res.status = 1'b0;
                end
            end
            OP_DELETE: begin
                if (p >= 0 && p < list_len) begin
                    for (int j = p + 1; j < list_len; j++)
                        list_cells[j - 1] = list_cells[j];
                    list_len--;
                    res.status = 1'b0;
                end
            end
            default: begin
                // unused code: refused, list unchanged
            end
        endcase
        res.item_count = list_len[CNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: slave-side source and master-side sink, both at the rising edge.
    // tvalid only drops once the current transfer has gone through.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ops
        list_op_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = op_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, nxt.value, nxt.pos, nxt.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: watches all three channels. Limit writes and accepted ops are
    // applied to the model before the result side is checked, so the order of
    // processes within a time step cannot matter.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        list_op_t     seen_op;
        list_result_t want;
        list_result_t got;
        if (!i_rst_n) begin
            list_len  = 0;
            limit_reg = LIMIT_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                limit_reg = i_cfg_data;
                limits_applied++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_op.op    = s_axis_tdata[1:0];
                seen_op.pos   = s_axis_tdata[6:2];
                seen_op.value = s_axis_tdata[38:7];
                want = apply_list_op(seen_op);
                if (want.status)
                    refusals++;
                pending_results.push_back(want);
                ops_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status     = m_axis_tdata[0];
                got.read_value = m_axis_tdata[32:1];
                got.item_count = m_axis_tdata[37:33];
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: tdata 0x%h",
                           m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d actual %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        mismatches++;
                    end
                    if (got.item_count !== want.item_count) begin
                        $error("item_count: expected %0d actual %0d",
                               want.item_count, got.item_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL position_indexed_array_list_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_op(input logic [OP_W-1:0] op, input int pos,
                            input logic [DATA_W-1:0] value);
        list_op_t item;
        item.op    = op;
        item.pos   = pos[POS_W-1:0];
        item.value = value;
        op_backlog.push_back(item);
        ops_issued++;
    endtask

    // blocks until every op has gone in and every result has come back
    task automatic wait_for_idle();
        while (ops_taken != ops_issued || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only ever called with the unit idle
    task automatic write_limit(input logic [LIM_W-1:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed ops aimed at the current count; about one in seven
    // is noise with any op code and any position.
    task automatic queue_random_op(input int ins_pct);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        int               roll;
        int               p;
        if ($urandom_range(0, 99) < 15) begin
            op  = OP_W'($urandom_range(0, 3));
            pos = POS_W'($urandom_range(0, 31));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                op = OP_INSERT;
            else if (roll < ins_pct + (100 - ins_pct) / 2)
                op = OP_READ;
            else
                op = OP_DELETE;
            if (op == OP_INSERT)
                pos = POS_W'($urandom_range(0, gen_len) - 1);
            else if (gen_len == 0)
                pos = '0;
            else
                pos = POS_W'($urandom_range(0, gen_len - 1));
        end
        // keep the aiming count in step
        p = $signed(pos);
        if (op == OP_INSERT && p >= -1 && p < gen_len && gen_len < gen_lim)
            gen_len++;
        else if (op == OP_DELETE && p >= 0 && p < gen_len)
            gen_len--;
        queue_op(op, p, $urandom());
    endtask

    task automatic run_phase(input logic [LIM_W-1:0] lim, input int n_ops,
                             input int send_pct, input int recv_pct,
                             input int ins_pct, input bit hold_mid);
        write_limit(lim);
        gen_lim        = (lim > CAPACITY) ? CAPACITY : int'(lim);
        gen_len        = list_len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n_ops; i++) begin
            // source holds off until the unit has fully drained
            if (hold_mid && i == n_ops / 2)
                wait_for_idle();
            queue_random_op(ins_pct);
        end
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, front / middle / end inserts, value extremes,
        // bad positions on both sides, the unused op code, deletes at both ends
        write_limit(5'd16);
        queue_op(OP_READ,    0,   32'd0);         // empty list
        queue_op(OP_DELETE,  0,   32'd0);         // empty list
        queue_op(OP_INSERT,  0,   32'd5);         // past end of empty list
        queue_op(OP_INSERT,  -1,  32'h7FFF_FFFF); // front
        queue_op(OP_INSERT,  -1,  32'h8000_0000); // front again
        queue_op(OP_INSERT,  1,   32'h0000_0000); // end
        queue_op(OP_INSERT,  0,   32'hFFFF_FFFF); // middle
        queue_op(OP_INSERT,  -2,  32'd1);         // below front
        queue_op(OP_INSERT,  -16, 32'd1);
        queue_op(OP_INSERT,  15,  32'd1);
        queue_op(OP_INSERT,  4,   32'd1);         // one past last
        for (int i = 0; i < 4; i++)
            queue_op(OP_READ, i, 32'hDEAD_BEEF);
        queue_op(OP_READ,    4,   32'd0);         // at count
        queue_op(OP_READ,    -1,  32'd0);
        queue_op(OP_READ,    15,  32'd0);
        queue_op(OP_READ,    -16, 32'd0);
        queue_op(OP_UNUSED,  0,   32'hA5A5_A5A5);
        queue_op(OP_DELETE,  3,   32'd0);         // last entry
        queue_op(OP_DELETE,  0,   32'd0);         // first entry
        queue_op(OP_DELETE,  -1,  32'd0);
        queue_op(OP_DELETE,  2,   32'd0);         // at count
        queue_op(OP_READ,    1,   32'd0);
        wait_for_idle();

        // random phases: limit, ops, source idle %, sink stall %, insert %, mid-phase drain
        run_phase(5'd16, 120, 0,  0,  60, 1'b0);  // fills to CAPACITY
        run_phase(5'd31, 90,  74, 0,  50, 1'b0);  // limit above CAPACITY
        run_phase(5'd3,  80,  0,  74, 30, 1'b0);  // limit below count
        run_phase(5'd1,  70,  15, 15, 50, 1'b0);
        run_phase(5'd0,  40,  74, 74, 40, 1'b0);  // every insert refused
        run_phase(5'd8,  90,  15, 15, 55, 1'b1);  // mid-phase drain

        $display("Covered %0d list ops (%0d refused) and %0d results across %0d limit writes.",
                 ops_taken, refusals, results_seen, limits_applied);
        $display("Limits 0, 1, 3, 8, 16 and 31 with idle and stall mixes; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("PASS position_indexed_array_list_unit");
        end else begin
            $display("FAIL position_indexed_array_list_unit");
        end
        $finish;
    end

endmodule

@@ position_indexed_array_list_unit.f @@
sv/pial_pkg.sv
sv/pial_ctrl.sv
sv/pial_dp.sv
sv/position_indexed_array_list_unit.sv
tb/sv/tb_position_indexed_array_list_unit.sv
